>>> rtl/sbus_pkg.sv
// Shared constants and types for the S.BUS frame decoder.
package sbus_pkg;

  localparam int FRAME_LEN     = 25;
  localparam int WIN_DEPTH     = FRAME_LEN - 1;
  localparam int FILL_W        = 5;
  localparam int PAYLOAD_BYTES = 22;
  localparam int NUM_CH        = 16;
  localparam int CH_BITS       = 11;
  localparam int CH_IDX_W      = 4;
  localparam int FRAME_W       = PAYLOAD_BYTES * 8;

  localparam logic [7:0] START_BYTE   = 8'h0F;
  localparam logic [7:0] END_BYTE     = 8'h00;
  localparam logic [7:0] ALT_END_RST  = 8'h04;

  localparam int          ADDR_W      = 3;
  localparam logic        REG_ALT_END = 1'b0;

  localparam logic [FILL_W-1:0]   FILL_FULL = FILL_W'(WIN_DEPTH);
  localparam logic [CH_IDX_W-1:0] LAST_CH   = CH_IDX_W'(NUM_CH - 1);

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Pick channel k out of the packed payload, LSB first.
  function automatic logic [CH_BITS-1:0] unpack_channel(
    input frame_t                 frame,
    input logic [CH_IDX_W-1:0]    k
  );
    logic [CH_BITS-1:0] v;
    v = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (k == CH_IDX_W'(i)) begin
        v = frame[i*CH_BITS +: CH_BITS];
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/sbus_front.sv
// Byte window, frame check and frame push toward the queue.
module sbus_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_rx_byte,
  input  logic [7:0]             alt_end_byte,
  input  sbus_pkg::q_stat_t      q_stat,
  output logic                   push,
  output sbus_pkg::frame_t       push_frame
);
  import sbus_pkg::*;

  logic [7:0]        win_r [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              acc;
  logic              complete;
  logic              frame_ok;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign complete = (fill_r == FILL_FULL);
  assign frame_ok = complete && (win_r[0] == START_BYTE) &&
                    ((in_rx_byte == END_BYTE) || (in_rx_byte == alt_end_byte));
  assign push     = acc && frame_ok;

  always_comb begin
    for (int j = 0; j < PAYLOAD_BYTES; j++) begin
      push_frame[j*8 +: 8] = win_r[j+1];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (acc) begin
      if (!complete) begin
        fill_nxt = fill_r + 1'b1;
      end else if (frame_ok) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Fill at the write position, or slide by one byte on a bad frame.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (!complete) begin
        win_r[fill_r] <= in_rx_byte;
      end else if (!frame_ok) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_DEPTH-1] <= in_rx_byte;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill count out of range");

  a_empty_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> fill_r == '0)
    else $error("window not emptied after a good frame");

  a_slide_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    acc && complete && !frame_ok |=> fill_r == FILL_FULL)
    else $error("window lost bytes on resync");

endmodule

>>> rtl/sbus_fq.sv
// Small frame queue between the window and the channel unpacker.
module sbus_fq #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sbus_pkg::frame_t     push_frame,
  input  logic                 pop,
  output sbus_pkg::frame_t     head,
  output sbus_pkg::q_stat_t    stat
);
  import sbus_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r;
  logic [PTR_W-1:0]  rd_r;
  logic [CNT_W-1:0]  cnt_r;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_frame;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("frame queue underflow");

endmodule

>>> rtl/sbus_back.sv
// Channel unpacker: walks the head frame and drives the result register.
module sbus_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbus_pkg::frame_t                  head,
  input  sbus_pkg::q_stat_t                 q_stat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sbus_pkg::CH_IDX_W-1:0]     out_channel_index,
  output logic [sbus_pkg::CH_BITS-1:0]      out_channel_value,
  output logic                              out_last_of_frame
);
  import sbus_pkg::*;

  logic [CH_IDX_W-1:0] ch_r;
  logic                out_valid_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic [CH_BITS-1:0]  val_r;
  logic                last_r;
  logic                adv;

  assign adv = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop = adv && (ch_r == LAST_CH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        ch_r        <= ch_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= ch_r;
      val_r  <= unpack_channel(head, ch_r);
      last_r <= (ch_r == LAST_CH);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = val_r;
  assign out_last_of_frame = last_r;

  // Inside a frame, once a channel is taken the next one is always ready on the following cycle.
  a_frame_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !last_r
      |=> out_valid_r && (idx_r == $past(idx_r) + 1'b1))
    else $error("gap or skip inside a frame");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && last_r)
    else $error("frame released without its last channel");

endmodule

>>> rtl/sbus_frame_decoder.sv
// S.BUS frame decoder: one received byte per clock in, sixteen 11-bit channels out per good
// frame. A byte is taken every cycle while the frame queue (QUEUE_DEPTH frames) has room;
// in_ready drops only when it is full. Each good frame's channels leave through the output
// register one per cycle in channel order while out_ready is high, so at that rate a frame's
// 16 channels leave before the 25 bytes of the next frame can arrive. A byte that completes a
// window with a wrong start or end byte slides the window by one and yields nothing.
module sbus_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sbus_pkg::CH_IDX_W-1:0]     out_channel_index,
  output logic [sbus_pkg::CH_BITS-1:0]      out_channel_value,
  output logic                              out_last_of_frame,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbus_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import sbus_pkg::*;

  logic [7:0] alt_end_r;
  logic       push;
  frame_t     push_frame;
  logic       pop;
  frame_t     head;
  q_stat_t    q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALT_END) ? {24'b0, alt_end_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_end_r <= ALT_END_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ALT_END)) begin
      alt_end_r <= pwdata[7:0];
    end
  end

  sbus_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .alt_end_byte (alt_end_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_frame   (push_frame)
  );

  sbus_fq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  sbus_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the S.BUS frame decoder: byte stream in, channel words out.
module tb_top;
  import sbus_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_STALL    = 500;
  localparam int PHASE_BYTES   = 60;
  localparam int STALL_FRAMES  = 4;

  localparam logic [ADDR_W-1:0] ADDR_ALT_END = ADDR_W'(4 * REG_ALT_END);
  localparam logic [ADDR_W-1:0] ADDR_SPARE   = ADDR_W'(4);

  typedef struct packed {
    logic [CH_IDX_W-1:0] index;
    logic [CH_BITS-1:0]  value;
    logic                last;
  } chan_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_ready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = 32'h0;
  logic                in_ready;
  logic                out_valid;
  logic [CH_IDX_W-1:0] out_channel_index;
  logic [CH_BITS-1:0]  out_channel_value;
  logic                out_last_of_frame;
  logic [31:0]         prdata;
  logic                pready;

  // Decoder mirror: byte window, fill level and end-byte register.
  logic [7:0]  frame_buf [FRAME_LEN];
  int unsigned buf_fill = 0;
  logic [7:0]  alt_end_q = ALT_END_RST;

  chan_word_t  pending_channels [$];
  logic [7:0]  tx_bytes [$];

  bit in_took = 1'b0;
  bit idle_on = 1'b1;
  bit stall_req = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int stall_left = 0;
  int cycles = 0;
  int err_cnt = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int alt_settings = 1;
  int held_off_cycles = 0;

  sbus_frame_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_of_frame (out_last_of_frame),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame_buf[i] = 8'h00;
    end
  end

  task automatic decode_byte(input logic [7:0] b);
    logic [23:0] span;
    int unsigned bitpos;
    int unsigned pos;
    chan_word_t  w;
    if (buf_fill >= FRAME_LEN) begin
      buf_fill = FRAME_LEN - 1;
    end
    frame_buf[buf_fill] = b;
    buf_fill++;
    if (buf_fill == FRAME_LEN) begin
      if (frame_buf[0] == START_BYTE && (frame_buf[FRAME_LEN-1] == END_BYTE ||
                                         frame_buf[FRAME_LEN-1] == alt_end_q)) begin
        for (int k = 0; k < NUM_CH; k++) begin
          bitpos  = k * CH_BITS;
          pos     = 1 + bitpos / 8;
          span    = {frame_buf[pos+2], frame_buf[pos+1], frame_buf[pos]};
          w.index = CH_IDX_W'(k);
          w.value = CH_BITS'(span >> (bitpos % 8));
          w.last  = (k == NUM_CH - 1);
          pending_channels.push_back(w);
        end
        buf_fill = 0;
        frames_seen++;
      end else begin
        // slide by one byte to resync
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
          frame_buf[i] = frame_buf[i+1];
        end
        buf_fill = FRAME_LEN - 1;
      end
    end
  endtask

  function automatic void push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  task automatic push_frame(input bit good);
    bit         bad_start;
    int         style;
    logic [7:0] head;
    logic [7:0] tail;
    bad_start = !good && ($urandom_range(0, 1) == 1);
    style     = $urandom_range(0, 7);
    head      = START_BYTE;
    while (bad_start && head == START_BYTE) begin
      head = 8'($urandom);
    end
    push_byte(head);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (style == 0) begin
        push_byte(8'hFF);
      end else if (style == 1) begin
        push_byte(8'h00);
      end else begin
        push_byte(8'($urandom));
      end
    end
    if (good || bad_start) begin
      tail = ($urandom_range(0, 1) == 1) ? END_BYTE : alt_end_q;
    end else begin
      tail = 8'($urandom);
      while (tail == END_BYTE || tail == alt_end_q) begin
        tail = 8'($urandom);
      end
    end
    push_byte(tail);
  endtask

  // Mostly good frames with random content; the rest broken frames and line noise.
  task automatic gen_traffic(input int n);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        push_frame(1'b1);
      end else if (pick < 17) begin
        push_frame(1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() > 0 || in_valid || pending_channels.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ALT_END) begin
      alt_end_q = data[7:0];
    end
  endtask

  task automatic check_alt_reg();
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ALT_END;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] !== alt_end_q) begin
      $error("alt_end_byte readback: expected %0h, actual %0h", alt_end_q, rd[7:0]);
      err_cnt++;
    end
  endtask

  task automatic set_alt(input logic [7:0] v);
    // junk in the upper bits must be dropped
    reg_write(ADDR_ALT_END, {24'($urandom), v});
    alt_settings++;
    check_alt_reg();
  endtask

  // Byte sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the request until accepted
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (tx_bytes.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
      tx_gap = $urandom_range(1, 18) - 1;
      in_valid <= 1'b0;
    end else if (tx_bytes.size() > 0) begin
      in_valid   <= 1'b1;
      in_rx_byte <= tx_bytes.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Channel receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_req) begin
        stall_left = LONG_STALL;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin : monitor
    chan_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      in_took = in_valid && in_ready;
      if (rst_n) begin
        if (in_valid && !in_ready) begin
          held_off_cycles++;
        end
        if (out_valid && out_ready) begin
          results_seen++;
          if (pending_channels.size() == 0) begin
            $error("unexpected channel word: index %0d value %0d last %0d",
                   out_channel_index, out_channel_value, out_last_of_frame);
            err_cnt++;
          end else begin
            want = pending_channels.pop_front();
            if (out_channel_index !== want.index) begin
              $error("channel_index: expected %0d, actual %0d", want.index, out_channel_index);
              err_cnt++;
            end
            if (out_channel_value !== want.value) begin
              $error("channel_value: expected %0d, actual %0d", want.value, out_channel_value);
              err_cnt++;
            end
            if (out_last_of_frame !== want.last) begin
              $error("last_of_frame: expected %0d, actual %0d", want.last, out_last_of_frame);
              err_cnt++;
            end
          end
        end
        if (in_took) begin
          bytes_taken++;
          decode_byte(in_rx_byte);
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the end byte, then one frame: channels 0-7 all ones, 8-15 all zeros,
    // closed by the alternate end byte.
    check_alt_reg();
    push_byte(START_BYTE);
    repeat (PAYLOAD_BYTES / 2) push_byte(8'hFF);
    repeat (PAYLOAD_BYTES / 2) push_byte(8'h00);
    push_byte(ALT_END_RST);
    wait_drained();

    // An unmapped address must leave the end byte alone.
    reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    check_alt_reg();

    // Zero alternate: only 0x00 closes a frame.
    set_alt(8'h00);
    gen_traffic(PHASE_BYTES);
    wait_drained();

    // Back-to-back good frames against a long output stall to fill the frame queue.
    set_alt(8'hFF);
    @(posedge clk);
    stall_req = 1'b1;
    repeat (STALL_FRAMES) push_frame(1'b1);
    wait_drained();

    set_alt(8'($urandom));
    gen_traffic(PHASE_BYTES);
    wait_drained();

    // Start byte doubling as end byte; full rate on both sides.
    idle_on = 1'b0;
    set_alt(START_BYTE);
    gen_traffic(PHASE_BYTES + 5);
    wait_drained();

    $display("Run: %0d bytes in, %0d frames decoded, %0d channel words out, %0d end-byte values.",
             bytes_taken, frames_seen, results_seen, alt_settings);
    $display("Input held off for %0d cycles by output back-pressure.", held_off_cycles);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
